// ===== rtl/pcx_pkg.sv =====
// ----------------------------------------------------------------------------
// pcx_pkg
// Shared constants and types of the PCX run-length decoder.
// ----------------------------------------------------------------------------
package pcx_pkg;

    // Sizes
    localparam int PALETTE_DEPTH = 256;
    localparam int MAX_PLANES    = 4;
    localparam int MAX_RUN       = 63;

    localparam int PAL_AW  = $clog2(PALETTE_DEPTH);
    localparam int RUN_W   = $clog2(MAX_RUN + 1);
    localparam int COLOR_W = 24;
    localparam int BYTE_W  = 8;
    localparam int DIM_W   = 16;
    localparam int PLANE_W = 2;
    localparam int PCNT_W  = 3;

    // Stream byte with both top bits set opens a run
    localparam logic [BYTE_W-1:0] RUN_MARK = 8'hC0;

    // Input actions
    localparam logic ACT_STREAM  = 1'b0;
    localparam logic ACT_PALETTE = 1'b1;

    // APB register map
    localparam int REG_IDX_W = 2;
    localparam int PADDR_W   = REG_IDX_W + 2;
    localparam int PDATA_W   = 32;

    localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_PLANE_COUNT  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_PALETTE_MODE = 2'd3;

    // Effective image configuration (zero sizes and plane count clamped)
    typedef struct packed {
        logic [DIM_W-1:0]  width;
        logic [DIM_W-1:0]  height;
        logic [PCNT_W-1:0] planes;
        logic              palette_mode;
    } cfg_t;

    // Palette RAM port request
    typedef struct packed {
        logic              we;
        logic [PAL_AW-1:0] waddr;
        logic [COLOR_W-1:0] wdata;
        logic              re;
        logic [PAL_AW-1:0] raddr;
    } ram_req_t;

endpackage

// ===== rtl/pcx_ram.sv =====
// ----------------------------------------------------------------------------
// pcx_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pcx_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/pcx_cfg.sv =====
// ----------------------------------------------------------------------------
// pcx_cfg
// APB register file for image size, plane count and palette mode.
// ----------------------------------------------------------------------------
module pcx_cfg
    import pcx_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    logic [DIM_W-1:0]     width_reg;
    logic [DIM_W-1:0]     height_reg;
    logic [PCNT_W-1:0]    planes_reg;
    logic                 mode_reg;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_W'(1);
            height_reg <= DIM_W'(1);
            planes_reg <= PCNT_W'(1);
            mode_reg   <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[DIM_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[DIM_W-1:0];
                REG_PLANE_COUNT:  planes_reg <= pwdata[PCNT_W-1:0];
                REG_PALETTE_MODE: mode_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Read-back of the raw register values
    always_comb begin
        case (reg_idx)
            REG_IMAGE_WIDTH:  prdata = PDATA_W'(width_reg);
            REG_IMAGE_HEIGHT: prdata = PDATA_W'(height_reg);
            REG_PLANE_COUNT:  prdata = PDATA_W'(planes_reg);
            REG_PALETTE_MODE: prdata = PDATA_W'(mode_reg);
            default:          prdata = '0;
        endcase
    end

    // Effective values: zero sizes act as 1, plane count clamped to 1..MAX_PLANES
    always_comb begin
        cfg.width        = (width_reg == '0) ? DIM_W'(1) : width_reg;
        cfg.height       = (height_reg == '0) ? DIM_W'(1) : height_reg;
        cfg.palette_mode = mode_reg;
        if (planes_reg == '0) begin
            cfg.planes = PCNT_W'(1);
        end else if (planes_reg > PCNT_W'(MAX_PLANES)) begin
            cfg.planes = PCNT_W'(MAX_PLANES);
        end else begin
            cfg.planes = planes_reg;
        end
    end

endmodule

// ===== rtl/pcx_seq.sv =====
// ----------------------------------------------------------------------------
// pcx_seq
// Stream parser and run sequencer: decodes run markers, reads the palette
// RAM, steps the raster position and drives the result register.
// ----------------------------------------------------------------------------
module pcx_seq
    import pcx_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  cfg_t                cfg,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    input  logic [BYTE_W-1:0]   s_stream_byte,
    input  logic [BYTE_W-1:0]   s_palette_index,
    input  logic [COLOR_W-1:0]  s_palette_color,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [COLOR_W-1:0]  m_pixel_value,
    output logic [DIM_W-1:0]    m_pixel_row,
    output logic [DIM_W-1:0]    m_pixel_column,
    output logic [PLANE_W-1:0]  m_pixel_plane,
    output logic                m_run_last,
    output logic                m_image_done,
    output ram_req_t            ram_req,
    input  logic [COLOR_W-1:0]  ram_rdata
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_END  = 2'd2;

    // Control state
    logic [1:0]         state_reg, state_next;
    logic               pending_reg, pending_next;
    logic [RUN_W-1:0]   run_len_reg, run_len_next;
    logic [DIM_W-1:0]   col_reg, col_next;
    logic [PLANE_W-1:0] plane_reg, plane_next;
    logic [DIM_W-1:0]   row_reg, row_next;
    logic               done_reg, done_next;
    logic               m_valid_reg, m_valid_next;

    // Payload of the current run and of the result register
    logic [RUN_W-1:0]   cnt_reg, cnt_next;
    logic [BYTE_W-1:0]  byte_reg, byte_next;
    logic               oob_reg, oob_next;
    logic [COLOR_W-1:0] value_reg, value_next;
    logic [DIM_W-1:0]   prow_reg, prow_next;
    logic [DIM_W-1:0]   pcol_reg, pcol_next;
    logic [PLANE_W-1:0] pplane_reg, pplane_next;
    logic               last_reg, last_next;
    logic               fin_reg, fin_next;

    logic s_acc;
    logic out_free;
    logic marker;
    logic start;
    logic [RUN_W-1:0] count;

    // Palette mode step: wrap before the pixel, emit, wrap after
    logic             wrap1, done1, wrap2, done3, pal_fin, pal_last;
    logic [DIM_W-1:0] col1, row1, row3, col3;
    logic [DIM_W:0]   col1_inc, row1_inc;

    // Plane mode step
    logic              pln_fin, pln_last;
    logic [DIM_W:0]    col_inc, row_inc, w_ext, h_ext;
    logic [PCNT_W-1:0] plane_inc;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_acc    = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign marker   = (s_stream_byte & RUN_MARK) == RUN_MARK;
    assign w_ext    = {1'b0, cfg.width};
    assign h_ext    = {1'b0, cfg.height};

    assign wrap1    = col_reg >= cfg.width;
    assign col1     = wrap1 ? '0 : col_reg;
    assign row1     = wrap1 ? DIM_W'(row_reg + 1'b1) : row_reg;
    assign done1    = done_reg || (wrap1 && row1 == '0) || (row1 >= cfg.height);
    assign col1_inc = {1'b0, col1} + 1'b1;
    assign row1_inc = {1'b0, row1} + 1'b1;
    assign pal_fin  = (col1_inc >= w_ext) && (row1_inc >= h_ext);
    assign wrap2    = col1_inc >= w_ext;
    assign col3     = wrap2 ? '0 : col1_inc[DIM_W-1:0];
    assign row3     = wrap2 ? row1_inc[DIM_W-1:0] : row1;
    assign done3    = (wrap2 && row3 == '0) || (row3 >= cfg.height);
    assign pal_last = (cnt_reg == RUN_W'(1)) || done3;

    assign col_inc   = {1'b0, col_reg} + 1'b1;
    assign row_inc   = {1'b0, row_reg} + 1'b1;
    assign plane_inc = {1'b0, plane_reg} + 1'b1;
    assign pln_fin   = (col_inc >= w_ext) && (plane_inc >= cfg.planes) && (row_inc >= h_ext);
    assign pln_last  = (cnt_reg == RUN_W'(1)) || (col_inc >= w_ext);

    // Stream byte decode: run marker, run value or literal
    always_comb begin
        start        = 1'b0;
        count        = RUN_W'(1);
        pending_next = pending_reg;
        run_len_next = run_len_reg;
        if (s_acc && s_action == ACT_STREAM) begin
            if (pending_reg) begin
                start        = 1'b1;
                count        = run_len_reg;
                pending_next = 1'b0;
                run_len_next = '0;
            end else if (marker) begin
                pending_next = 1'b1;
                run_len_next = s_stream_byte[RUN_W-1:0];
            end else begin
                start = 1'b1;
            end
        end
    end

    // Palette RAM: writes from palette requests, one read per decoded value
    always_comb begin
        ram_req.we    = s_acc && s_action == ACT_PALETTE &&
                        ({1'b0, s_palette_index} < (BYTE_W + 1)'(PALETTE_DEPTH));
        ram_req.waddr = s_palette_index[PAL_AW-1:0];
        ram_req.wdata = s_palette_color;
        ram_req.re    = start;
        ram_req.raddr = s_stream_byte[PAL_AW-1:0];
    end

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        col_next     = col_reg;
        plane_next   = plane_reg;
        row_next     = row_reg;
        done_next    = done_reg;
        cnt_next     = cnt_reg;
        byte_next    = byte_reg;
        oob_next     = oob_reg;
        m_valid_next = m_valid_reg && !m_ready;
        value_next   = value_reg;
        prow_next    = prow_reg;
        pcol_next    = pcol_reg;
        pplane_next  = pplane_reg;
        last_next    = last_reg;
        fin_next     = fin_reg;

        case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    cnt_next  = count;
                    byte_next = s_stream_byte;
                    oob_next  = {1'b0, s_stream_byte} >= (BYTE_W + 1)'(PALETTE_DEPTH);
                    if (cfg.palette_mode) begin
                        if (count != '0 && !done_reg) begin
                            state_next = ST_RUN;
                        end
                    end else if (!done_reg) begin
                        if (row_reg >= cfg.height) begin
                            done_next = 1'b1;
                        end else if (count != '0 && col_reg < cfg.width) begin
                            state_next = ST_RUN;
                        end else begin
                            state_next = ST_END;
                        end
                    end
                end
            end

            ST_RUN: begin
                if (out_free) begin
                    cnt_next = cnt_reg - 1'b1;
                    if (cfg.palette_mode) begin
                        if (done1) begin
                            // image already full: drop the rest of the run
                            col_next   = col1;
                            row_next   = row1;
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end else begin
                            m_valid_next = 1'b1;
                            value_next   = oob_reg ? '0 : ram_rdata;
                            prow_next    = row1;
                            pcol_next    = col1;
                            pplane_next  = '0;
                            last_next    = pal_last;
                            fin_next     = pal_fin;
                            col_next     = col3;
                            row_next     = row3;
                            done_next    = done3;
                            if (pal_last) begin
                                state_next = ST_IDLE;
                            end
                        end
                    end else begin
                        m_valid_next = 1'b1;
                        value_next   = COLOR_W'(byte_reg);
                        prow_next    = row_reg;
                        pcol_next    = col_reg;
                        pplane_next  = plane_reg;
                        last_next    = pln_last;
                        fin_next     = pln_fin;
                        col_next     = col_inc[DIM_W-1:0];
                        if (pln_last) begin
                            state_next = ST_END;
                        end
                    end
                end
            end

            ST_END: begin
                // end of a plane-mode request: once the line is full, move to next plane or scanline
                if (col_reg >= cfg.width) begin
                    col_next = '0;
                    if (plane_inc >= cfg.planes) begin
                        plane_next = '0;
                        row_next   = row_inc[DIM_W-1:0];
                        done_next  = done_reg || (row_inc >= h_ext);
                    end else begin
                        plane_next = plane_inc[PLANE_W-1:0];
                    end
                end
                state_next = ST_IDLE;
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pending_reg <= 1'b0;
            run_len_reg <= '0;
            col_reg     <= '0;
            plane_reg   <= '0;
            row_reg     <= '0;
            done_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
            run_len_reg <= run_len_next;
            col_reg     <= col_next;
            plane_reg   <= plane_next;
            row_reg     <= row_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cnt_reg    <= cnt_next;
        byte_reg   <= byte_next;
        oob_reg    <= oob_next;
        value_reg  <= value_next;
        prow_reg   <= prow_next;
        pcol_reg   <= pcol_next;
        pplane_reg <= pplane_next;
        last_reg   <= last_next;
        fin_reg    <= fin_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_value  = value_reg;
    assign m_pixel_row    = prow_reg;
    assign m_pixel_column = pcol_reg;
    assign m_pixel_plane  = pplane_reg;
    assign m_run_last     = last_reg;
    assign m_image_done   = fin_reg;

endmodule

// ===== rtl/pcx_rle_decoder.sv =====
// ----------------------------------------------------------------------------
// pcx_rle_decoder
// PCX run-length stream decoder with palette expansion and plane output.
// ----------------------------------------------------------------------------
// The decoder takes one request per cycle when it is idle. Palette writes and
// run-marker bytes give no pixel and leave the decoder idle. A value byte that
// yields pixels holds the input while its run is emitted, and in plane mode
// also through the end state, which moves to the next plane or scanline once
// the line is full. In palette mode a run that finds the image already full
// at its first step is dropped in the run state with no pixel. Once the image
// is done, or a plane-mode byte finds the last row passed, a value byte leaves
// the decoder idle and gives no pixel. The run counter emits one pixel per
// cycle into a single result register, and a stall on the result side
// stretches the run. The palette is a 256 x 24 RAM with a registered read
// issued when the value byte is taken; it is not cleared at reset, so every
// entry must be written before a pixel reads it. Configure the image only
// while idle.
// ----------------------------------------------------------------------------
module pcx_rle_decoder
    import pcx_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready,
    // input requests
    input  logic                s_valid,
    output logic                s_ready,
    input  logic                s_action,
    input  logic [BYTE_W-1:0]   s_stream_byte,
    input  logic [BYTE_W-1:0]   s_palette_index,
    input  logic [COLOR_W-1:0]  s_palette_color,
    // decoded pixels
    output logic                m_valid,
    input  logic                m_ready,
    output logic [COLOR_W-1:0]  m_pixel_value,
    output logic [DIM_W-1:0]    m_pixel_row,
    output logic [DIM_W-1:0]    m_pixel_column,
    output logic [PLANE_W-1:0]  m_pixel_plane,
    output logic                m_run_last,
    output logic                m_image_done
);

    cfg_t               cfg;
    ram_req_t           ram_req;
    logic [COLOR_W-1:0] ram_rdata;

    // Register file
    pcx_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Palette store
    pcx_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk  (aclk),
        .we    (ram_req.we),
        .waddr (ram_req.waddr),
        .wdata (ram_req.wdata),
        .re    (ram_req.re),
        .raddr (ram_req.raddr),
        .rdata (ram_rdata)
    );

    // Parser and run sequencer
    pcx_seq u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg             (cfg),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_stream_byte   (s_stream_byte),
        .s_palette_index (s_palette_index),
        .s_palette_color (s_palette_color),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_pixel_value   (m_pixel_value),
        .m_pixel_row     (m_pixel_row),
        .m_pixel_column  (m_pixel_column),
        .m_pixel_plane   (m_pixel_plane),
        .m_run_last      (m_run_last),
        .m_image_done    (m_image_done),
        .ram_req         (ram_req),
        .ram_rdata       (ram_rdata)
    );

endmodule

// ===== rtl/pcx_chk.sv =====
// ----------------------------------------------------------------------------
// pcx_chk
// Port-level checks of the PCX decoder, bound to the top level.
// ----------------------------------------------------------------------------
module pcx_chk
    import pcx_pkg::*;
(
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                s_action,
    input logic                m_valid,
    input logic                m_ready,
    input logic [COLOR_W-1:0]  m_pixel_value,
    input logic [DIM_W-1:0]    m_pixel_row,
    input logic [DIM_W-1:0]    m_pixel_column,
    input logic [PLANE_W-1:0]  m_pixel_plane,
    input logic                m_run_last,
    input logic                m_image_done
);

    // No pixel is shown right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("pixel valid right after reset");

    // A stalled pixel holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_pixel_value) &&
        $stable(m_pixel_row) && $stable(m_pixel_column) &&
        $stable(m_pixel_plane) && $stable(m_run_last) && $stable(m_image_done))
        else $error("stalled pixel changed");

    // A palette write does not stall the input
    a_pal_write: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && s_action == ACT_PALETTE |=> s_ready)
        else $error("palette write stalled the input");

    // The pixel that completes the image ends its request
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_image_done |-> m_run_last)
        else $error("image done without run_last");

endmodule

bind pcx_rle_decoder pcx_chk u_pcx_chk (.*);
